// File: rtl/kmd_pkg.sv
package kmd_pkg;

  // Port widths, fixed by the field layout
  localparam int IN_TDATA_W   = 56;  // 51 payload bits, padded to whole bytes
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int READ_W       = 8;   // column lines per read

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE  = 2'd2;

  // Operation codes (in_tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Command passed from the front end to the back end
  typedef struct packed {
    logic              op;
    logic [2:0]        row;
    logic [READ_W-1:0] pressed;  // per-column pressed pattern of this sample
  } kmd_cmd_t;

  // Queued key event
  typedef struct packed {
    logic       pressed;
    logic [2:0] col;
    logic [2:0] row;
  } kmd_event_t;

  // Effective configuration, plus a one-cycle clear on a count write
  typedef struct packed {
    logic       clear;
    logic [3:0] row_limit;  // rows in use, capped at the row capacity
    logic [3:0] col_limit;  // columns in use, capped at capacity and read width
    logic [7:0] need;       // debounce samples, zero taken as one
  } kmd_cfg_t;

endpackage

// File: rtl/kmd_front.sv
module kmd_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [kmd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                        in_tuser,
  input  kmd_pkg::kmd_cfg_t           cfg,
  output logic                        push,
  output kmd_pkg::kmd_cmd_t           push_cmd,
  input  logic                        q_full
);
  import kmd_pkg::*;

  logic [2:0]        row;
  logic [READ_W-1:0] idle1, idle2, idle3, act1, act2, act3;
  logic              row_ok;

  assign row   = in_tdata[2:0];
  assign idle1 = in_tdata[10:3];
  assign idle2 = in_tdata[18:11];
  assign idle3 = in_tdata[26:19];
  assign act1  = in_tdata[34:27];
  assign act2  = in_tdata[42:35];
  assign act3  = in_tdata[50:43];

  // A sample counts only with both counts set and the row in range
  assign row_ok = (cfg.col_limit != 4'd0) && ({1'b0, row} < cfg.row_limit);

  assign in_tready = !q_full;

  always_comb begin
    push_cmd.op      = in_tuser;
    push_cmd.row     = row;
    // pressed: high in every idle read, low in every active read
    push_cmd.pressed = idle1 & idle2 & idle3 & ~(act1 | act2 | act3);
    push = in_tvalid && !q_full && ((in_tuser == OP_READ) || row_ok);
  end

endmodule

// File: rtl/kmd_fifo.sv
module kmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kmd_pkg::kmd_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output kmd_pkg::kmd_cmd_t head_cmd
);
  import kmd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kmd_cmd_t          slot_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/kmd_back.sv
module kmd_back #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmd_pkg::kmd_cfg_t               cfg,
  input  logic                            cmd_valid,
  input  kmd_pkg::kmd_cmd_t               cmd,
  output logic                            cmd_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kmd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import kmd_pkg::*;

  localparam int NK    = MAX_ROWS * MAX_COLS;
  localparam int KEY_W = (NK > 1) ? $clog2(NK) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SCAN  = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;
  localparam logic [1:0] B_POP   = 2'd3;

  typedef struct packed {
    logic       raw;
    logic       stable;
    logic [7:0] cnt;
  } key_t;

  logic [1:0]        state_r, state_nxt;
  logic              key_rd, ring_rd, out_free, last_col;

  // scan context
  logic [2:0]        row_r;
  logic [READ_W-1:0] pressed_r;
  logic [2:0]        col_r;
  logic [KEY_W-1:0]  rd_addr;

  // key state memory, valid bits stand for the cleared state
  key_t              key_mem [NK];
  logic [NK-1:0]     key_vld_r;
  key_t              key_q_r;
  logic              key_v_r;
  logic              wr_pend_r;
  logic [2:0]        wcol_r;
  logic [KEY_W-1:0]  waddr_r;

  // per-key update
  key_t              cur, upd;
  logic              now, ev_push;

  // event ring
  kmd_event_t        ring_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  kmd_event_t        evt_q_r;
  logic              empty_r, more_r;

  // output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !out_tvalid_r || out_tready;
  assign last_col = (col_r == (cfg.col_limit[2:0] - 3'd1));
  assign rd_addr  = KEY_W'(int'(row_r) * MAX_COLS + int'(col_r));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    key_rd    = 1'b0;
    ring_rd   = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_SAMPLE) begin
            cmd_pop   = 1'b1;
            state_nxt = B_SCAN;
          end else if (out_free) begin
            cmd_pop   = 1'b1;
            ring_rd   = 1'b1;
            state_nxt = B_POP;
          end
        end
      end
      B_SCAN: begin
        key_rd = 1'b1;
        if (last_col) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: state_nxt = B_IDLE;
      B_POP:   state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= key_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      row_r     <= cmd.row;
      pressed_r <= cmd.pressed;
      col_r     <= '0;
    end else if (key_rd) begin
      col_r <= col_r + 3'd1;
    end
    if (key_rd) begin
      wcol_r  <= col_r;
      waddr_r <= rd_addr;
      key_q_r <= key_mem[rd_addr];
      key_v_r <= key_vld_r[rd_addr];
    end
  end

  // read-modify-write of one key, in the cycle after its read
  always_comb begin
    cur     = key_v_r ? key_q_r : '0;
    now     = pressed_r[wcol_r];
    upd     = cur;
    if (now == cur.raw) begin
      if (cur.cnt < cfg.need) begin
        upd.cnt = cur.cnt + 8'd1;
      end
    end else begin
      upd.raw = now;
      upd.cnt = 8'd1;
    end
    ev_push = 1'b0;
    if ((upd.cnt >= cfg.need) && (upd.stable != upd.raw)) begin
      upd.stable = upd.raw;
      ev_push    = wr_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      key_mem[waddr_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      key_vld_r <= '0;
    end else if (wr_pend_r) begin
      key_vld_r[waddr_r] <= 1'b1;
    end
  end

  // ring pointers; a push into a full ring drops the oldest entry
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cfg.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else if (ev_push) begin
      tail_nxt = bump(tail_r);
      if (bump(tail_r) == head_r) begin
        head_nxt = bump(head_r);
      end
    end else if (ring_rd && (head_r != tail_r)) begin
      head_nxt = bump(head_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) begin
      ring_mem[tail_r] <= '{pressed: upd.stable, col: wcol_r, row: row_r};
    end
    if (ring_rd) begin
      evt_q_r <= ring_mem[head_r];
      empty_r <= (head_r == tail_r);
      more_r  <= (bump(head_r) != tail_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == B_POP) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_POP) begin
      out_tuser_r <= !empty_r;
      out_tdata_r <= empty_r ? '0 :
                     {more_r, evt_q_r.pressed, evt_q_r.col, evt_q_r.row};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/keypad_matrix_debounce_events.sv
// Keypad matrix scanner with per-key debounce and an event queue. Each input
// beat is either a row sample (in_tuser = 0: a row index and three idle plus
// three active reads of the column lines) or an event read (in_tuser = 1).
// A key is pressed when its column is high in every idle read and low in every
// active read. A key changes its stable state once the same raw value has been
// seen debounce_samples times in a row (0 acts as 1); each change is queued as
// an event, and a full queue drops its oldest event (it holds QUEUE_DEPTH-1).
// Every read beat returns exactly one result beat: out_tuser = 1 with the
// event, or out_tuser = 0 and all-zero data when the queue is empty. Row
// samples give no result. Samples with row_count or col_count at zero, or with
// a row beyond row_count, are dropped at the input. Writing row_count or
// col_count clears all key state and empties the queue at once; write config
// only while no beats are in flight. A row sample is popped in the idle
// state, then the scan state visits each active column (at most 8) - the
// key-state RAM does one read and one write per column, with the last write
// drained in the drain state before the next beat starts. An event read is
// popped in the idle state once the result register is free, with the event
// RAM read into a register; the pop state then loads the result register and
// raises out_tvalid. A two-entry command queue before the execution side keeps
// taking input beats while a result waits on out_tready, until it is full.
module keypad_matrix_debounce_events #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] row_index, [10:3] idle_read_first, [18:11] idle_read_second,
  // [26:19] idle_read_third, [34:27] active_read_first,
  // [42:35] active_read_second, [50:43] active_read_third, [55:51] zero
  input  logic [kmd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,   // [0] operation
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] event_row, [5:3] event_col, [6] event_pressed, [7] more_pending
  output logic [kmd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,  // [0] event_valid
  // configuration writes
  input  logic                               cfg_we,
  input  logic [kmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kmd_pkg::*;

  // usable columns: capacity, but never wider than one read
  localparam int COL_CAP = (MAX_COLS < READ_W) ? MAX_COLS : READ_W;

  logic [3:0] row_count_r, row_count_nxt;
  logic [3:0] col_count_r, col_count_nxt;
  logic [7:0] debounce_r, debounce_nxt;
  logic       count_write;
  kmd_cfg_t   cfg;

  logic       q_push, q_full, q_pop, q_not_empty;
  kmd_cmd_t   q_in, q_head;

  // config registers
  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    debounce_nxt  = debounce_r;
    count_write   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_COUNT: begin
          row_count_nxt = cfg_wdata[3:0];
          count_write   = 1'b1;
        end
        REG_COL_COUNT: begin
          col_count_nxt = cfg_wdata[3:0];
          count_write   = 1'b1;
        end
        REG_DEBOUNCE:  debounce_nxt = cfg_wdata;
        default:       ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 4'd0;
      col_count_r <= 4'd0;
      debounce_r  <= 8'd1;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      debounce_r  <= debounce_nxt;
    end
  end

  always_comb begin
    cfg.clear     = count_write;
    cfg.row_limit = (int'(row_count_r) < MAX_ROWS) ? row_count_r : 4'(MAX_ROWS);
    cfg.col_limit = (int'(col_count_r) < COL_CAP) ? col_count_r : 4'(COL_CAP);
    cfg.need      = (debounce_r == 8'd0) ? 8'd1 : debounce_r;
  end

  // decode and filter incoming beats
  kmd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .push      (q_push),
    .push_cmd  (q_in),
    .q_full    (q_full)
  );

  // command queue between decode and execution
  kmd_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  // key state, debounce, event ring and result register
  kmd_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (q_not_empty),
    .cmd        (q_head),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/kmd_checker.sv
module kmd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kmd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import kmd_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // an empty-queue result carries all-zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty-queue result with nonzero data");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // each read goes through the pop state, so out_tvalid always drops
  // once a result is taken
  a_more_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("back-to-back results from the event side");

endmodule

bind keypad_matrix_debounce_events kmd_checker u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kmd_pkg::*;

  // Block geometry as instantiated (default parameters)
  localparam int MAX_ROWS_TB   = 8;
  localparam int KEYS_PER_ROW  = 8;
  localparam int RING_SLOTS    = 16;
  localparam int KEY_TOTAL     = MAX_ROWS_TB * KEYS_PER_ROW;
  // Worst in-flight work: two queued commands plus one executing row sample
  // and the read path; rounded up generously.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any beat or register write before the run is declared hung
  localparam int STALL_LIMIT   = 2000;

  // One result beat, in check order
  typedef struct packed {
    logic       valid;
    logic [2:0] row;
    logic [2:0] col;
    logic       pressed;
    logic       more;
  } key_event_t;

  localparam key_event_t NO_EVENT = '0;

  typedef enum logic {STEP_CFG, STEP_BEAT} step_kind_t;

  // Directed script row: either a register write or one input beat.
  // idle/act hold the three reads packed first read lowest, as on in_tdata.
  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [7:0]            reg_val;
    logic                  op;
    logic [2:0]            row;
    logic [23:0]           idle;
    logic [23:0]           act;
    logic                  typed;  // want is filled in by hand
    key_event_t            want;
  } script_step_t;

  // Random phase: settings to program and the shape of the traffic
  typedef struct packed {
    logic [2:0]  wr_mask;     // [0] row_count, [1] col_count, [2] debounce
    logic [3:0]  rows;
    logic [3:0]  cols;
    logic [7:0]  deb;
    logic [15:0] items;
    logic [7:0]  read_pct;
    logic [7:0]  bounce_pct;  // chance of a bouncing read; half of it is pure noise
    logic [7:0]  change_pct;  // chance a row's held keys change
    logic        shuffle;     // pick counts and debounce at random instead
    logic        quiet;       // no idling on either side
  } phase_t;

  localparam int SCRIPT_LEN = 34;
  localparam int PHASE_COUNT = 9;
  localparam int TAIL_READS = 3;

  localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
    // out of reset: empty queue, sampling disabled
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd0, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1, NO_EVENT},
    // full matrix, debounce 0 acts as 1
    '{STEP_CFG, REG_ROW_COUNT, 8'd8, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_CFG, REG_COL_COUNT, 8'd8, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_CFG, REG_DEBOUNCE, 8'd0, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    // whole top row pressed: first pop is row 7 col 0, more behind it
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1,
      '{1'b1, 3'd7, 3'd0, 1'b1, 1'b1}},
    // one idle read low on col 0, one active read high on col 7
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd0, 24'hFFFEFF, 24'h000080, 1'b0,
      NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd3, 24'h000000, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd5, 24'hFFFFFF, 24'hFFFFFF, 1'b0,
      NO_EVENT},
    // two more full rows overflow the ring: oldest events drop
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd1, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd2, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    // release the even columns of row 7
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h555555, 1'b0,
      NO_EVENT},
    // debounce change alone keeps key state
    '{STEP_CFG, REG_DEBOUNCE, 8'd2, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    // count write empties the queue; row 5 now out of range
    '{STEP_CFG, REG_ROW_COUNT, 8'd3, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd5, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd2, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1, NO_EVENT},
    // counts above the limits, longest debounce
    '{STEP_CFG, REG_COL_COUNT, 8'd15, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_CFG, REG_ROW_COUNT, 8'd15, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_CFG, REG_DEBOUNCE, 8'd255, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b1, NO_EVENT},
    // drop to 1: the count already held fires on the next sample
    '{STEP_CFG, REG_DEBOUNCE, 8'd1, OP_SAMPLE, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_SAMPLE, 3'd7, 24'hFFFFFF, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT},
    '{STEP_BEAT, REG_ROW_COUNT, 8'd0, OP_READ, 3'd0, 24'h0, 24'h0, 1'b0, NO_EVENT}
  };

  localparam phase_t PHASES [PHASE_COUNT] = '{
    // mask    rows   cols   deb     items    read%  bnc%   chg%  shuf  quiet
    '{3'b111, 4'd8,  4'd8,  8'd1,   16'd250, 8'd30, 8'd10, 8'd8, 1'b0, 1'b0},
    '{3'b100, 4'd8,  4'd8,  8'd3,   16'd200, 8'd25, 8'd10, 8'd8, 1'b0, 1'b0},
    '{3'b111, 4'd0,  4'd0,  8'd0,   16'd100, 8'd25, 8'd12, 8'd8, 1'b1, 1'b0},
    '{3'b111, 4'd0,  4'd0,  8'd0,   16'd100, 8'd25, 8'd12, 8'd8, 1'b1, 1'b0},
    '{3'b111, 4'd15, 4'd15, 8'd0,   16'd150, 8'd30, 8'd15, 8'd8, 1'b0, 1'b0},
    '{3'b111, 4'd1,  4'd3,  8'd255, 16'd290, 8'd3,  8'd0,  8'd0, 1'b0, 1'b0},
    '{3'b011, 4'd0,  4'd8,  8'd0,   16'd40,  8'd30, 8'd10, 8'd8, 1'b0, 1'b0},
    '{3'b111, 4'd5,  4'd0,  8'd1,   16'd40,  8'd30, 8'd10, 8'd8, 1'b0, 1'b0},
    '{3'b111, 4'd4,  4'd8,  8'd2,   16'd150, 8'd30, 8'd10, 8'd8, 1'b0, 1'b1}
  };

  // Clock and DUT-facing signals; the driven ones are known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata  = '0;
  logic                  in_tuser  = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keypad_matrix_debounce_events DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Scanner predictor: settings, per-key debounce state and the event ring
  // ---------------------------------------------------------------------------
  logic [3:0]  rows_setting;
  logic [3:0]  cols_setting;
  logic [7:0]  debounce_setting;
  logic        key_raw     [KEY_TOTAL];
  logic        key_stable  [KEY_TOTAL];
  int          key_matches [KEY_TOTAL];
  kmd_event_t  event_ring  [RING_SLOTS];
  int          ring_rd;
  int          ring_wr;

  key_event_t  expected_events [$];  // pops still owed by the DUT, oldest first

  // Run bookkeeping
  int  errors       = 0;
  int  beats_in     = 0;
  int  reads_in     = 0;
  int  results_out  = 0;
  int  events_out   = 0;
  int  reg_writes   = 0;
  int  gap_pct      = 0;
  bit  quiet        = 1'b0;

  function automatic void clear_keys();
    for (int k = 0; k < KEY_TOTAL; k++) begin
      key_raw[k]     = 1'b0;
      key_stable[k]  = 1'b0;
      key_matches[k] = 0;
    end
    ring_rd = 0;
    ring_wr = 0;
  endfunction

  // Debounce one row sample; each accepted change lands in the ring,
  // pushing out the oldest entry when the ring is full.
  function automatic void predict_sample(logic [2:0] row, logic [23:0] idle,
                                         logic [23:0] act);
    int         rows;
    int         cols;
    int         need;
    int         k;
    int         slot_next;
    logic [7:0] hit;
    logic       now;
    rows = (rows_setting > MAX_ROWS_TB) ? MAX_ROWS_TB : rows_setting;
    cols = (cols_setting > KEYS_PER_ROW) ? KEYS_PER_ROW : cols_setting;
    need = (debounce_setting == 0) ? 1 : debounce_setting;
    if (rows == 0 || cols == 0 || row >= rows) return;
    // pressed: pulled high in every idle read, pulled low in every active read
    hit = idle[7:0] & idle[15:8] & idle[23:16] & ~(act[7:0] | act[15:8] | act[23:16]);
    for (int c = 0; c < cols; c++) begin
      k   = row * KEYS_PER_ROW + c;
      now = hit[c];
      if (now == key_raw[k]) begin
        if (key_matches[k] < need) key_matches[k]++;
      end else begin
        key_raw[k]     = now;
        key_matches[k] = 1;
      end
      if (key_matches[k] >= need && key_stable[k] != key_raw[k]) begin
        key_stable[k] = key_raw[k];
        slot_next = (ring_wr + 1) % RING_SLOTS;
        if (slot_next == ring_rd) ring_rd = (ring_rd + 1) % RING_SLOTS;
        event_ring[ring_wr] = '{pressed: now, col: 3'(c), row: row};
        ring_wr = slot_next;
      end
    end
  endfunction

  function automatic key_event_t predict_pop();
    key_event_t res;
    kmd_event_t ev;
    res = NO_EVENT;
    if (ring_rd != ring_wr) begin
      ev          = event_ring[ring_rd];
      ring_rd     = (ring_rd + 1) % RING_SLOTS;
      res.valid   = 1'b1;
      res.row     = ev.row;
      res.col     = ev.col;
      res.pressed = ev.pressed;
      res.more    = (ring_rd != ring_wr);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  // One register write; the caller drops cfg_we after the last of a group so
  // back-to-back writes never lower and raise it within one step.
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_ROW_COUNT: begin
        rows_setting = val[3:0];
        clear_keys();
      end
      REG_COL_COUNT: begin
        cols_setting = val[3:0];
        clear_keys();
      end
      REG_DEBOUNCE: debounce_setting = val;
      default: ;
    endcase
  endtask

  // Sender stops, every owed pop has come back, then row samples in flight
  // (which return nothing) get time to retire.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Present one beat, hold it until taken, then advance the predictor.
  // tvalid is left high; the next beat or a gap takes it over.
  task automatic drive_beat(input logic op, input logic [2:0] row, input logic [23:0] idle,
                            input logic [23:0] act, input logic typed,
                            input key_event_t want);
    key_event_t got;
    if (beats_in % 50 == 0) gap_pct = $urandom_range(0, 1) ? 20 : 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, act, idle, row};
    do @(posedge clk); while (!in_tready);
    beats_in++;
    if (op == OP_SAMPLE) begin
      predict_sample(row, idle, act);
    end else begin
      reads_in++;
      got = predict_pop();
      expected_events.push_back(typed ? want : got);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, with calm stretches of full throughput
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int calm_left;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left == 0) begin
        calm_left = $urandom_range(20, 200);
        calm      = ($urandom_range(0, 2) == 0);
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is matched against the oldest owed pop.
  // out_tdata: [2:0] row, [5:3] col, [6] pressed, [7] more; out_tuser: valid.
  always @(posedge clk) begin : result_check
    key_event_t got;
    key_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[2:0], out_tdata[5:3], out_tdata[6], out_tdata[7]};
      results_out++;
      if (got.valid) events_out++;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_valid", want.valid, got.valid);
        check_field("event_row", want.row, got.row);
        check_field("event_col", want.col, got.col);
        check_field("event_pressed", want.pressed, got.pressed);
        check_field("more_pending", want.more, got.more);
      end
    end
  end

  // Hang detector: any beat or register write resets the count
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: no progress for %0d cycles, %0d results still owed",
             $time, STALL_LIMIT, expected_events.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed script, then randomized phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    phase_t      ph;
    logic [7:0]  held [MAX_ROWS_TB];  // keys currently held down, per row
    logic [3:0]  rows_pick;
    logic [3:0]  cols_pick;
    logic [7:0]  deb_pick;
    logic        op;
    logic [2:0]  row;
    logic [23:0] idle;
    logic [23:0] act;
    logic [7:0]  flip;
    int          rows_eff;
    int          sel;

    rows_setting     = 4'd0;
    cols_setting     = 4'd0;
    debounce_setting = 8'd1;
    clear_keys();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register writes only with nothing in flight
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == STEP_CFG) begin
        if (i == 0 || SCRIPT[i-1].kind != STEP_CFG) wait_drained();
        reg_write(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
        if (i == SCRIPT_LEN - 1 || SCRIPT[i+1].kind != STEP_CFG) cfg_we <= 1'b0;
      end else begin
        drive_beat(SCRIPT[i].op, SCRIPT[i].row, SCRIPT[i].idle, SCRIPT[i].act,
                   SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    // Random phases. Most samples are clean scans of held keys so debounce
    // counts build up; some bounce, some are pure noise.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      ph = PHASES[p];
      wait_drained();
      rows_pick = ph.shuffle ? 4'($urandom_range(0, 15)) : ph.rows;
      cols_pick = ph.shuffle ? 4'($urandom_range(0, 15)) : ph.cols;
      deb_pick  = ph.shuffle ? 8'($urandom_range(0, 6)) : ph.deb;
      if (ph.wr_mask[0]) reg_write(REG_ROW_COUNT, {4'b0, rows_pick});
      if (ph.wr_mask[1]) reg_write(REG_COL_COUNT, {4'b0, cols_pick});
      if (ph.wr_mask[2]) reg_write(REG_DEBOUNCE, deb_pick);
      cfg_we <= 1'b0;
      quiet = ph.quiet;
      for (int r = 0; r < MAX_ROWS_TB; r++) held[r] = 8'($urandom_range(1, 255));
      rows_eff = (rows_setting > MAX_ROWS_TB) ? MAX_ROWS_TB : rows_setting;

      for (int n = 0; n < ph.items; n++) begin
        if ($urandom_range(0, 199) < ph.bounce_pct) begin
          op   = 1'($urandom_range(0, 1));
          row  = 3'($urandom_range(0, 7));
          idle = 24'($urandom);
          act  = 24'($urandom);
        end else begin
          op = ($urandom_range(0, 99) < ph.read_pct) ? OP_READ : OP_SAMPLE;
          if (rows_eff == 0 || (ph.bounce_pct != 0 && $urandom_range(0, 9) == 0))
            row = 3'($urandom_range(0, 7));
          else
            row = 3'($urandom_range(0, rows_eff - 1));
          if ($urandom_range(0, 99) < ph.change_pct) begin
            if ($urandom_range(0, 1)) held[row] = 8'($urandom);
            else held[row] = held[row] ^ (8'd1 << $urandom_range(0, 7));
          end
          idle = '1;
          act  = {3{~held[row]}};
          if ($urandom_range(0, 99) < ph.bounce_pct) begin
            sel  = $urandom_range(0, 5);
            flip = 8'($urandom_range(1, 255));
            if (sel < 3) idle[sel*8 +: 8] ^= flip;
            else act[(sel-3)*8 +: 8] ^= flip;
          end
          if (op == OP_READ) begin
            idle = 24'($urandom);
            act  = 24'($urandom);
          end
        end
        drive_beat(op, row, idle, act, 1'b0, NO_EVENT);
        // occasionally let the queue and the result side empty completely
        if (!quiet && $urandom_range(0, 149) == 0) wait_drained();
      end

      // TAIL_READS pops, so the oldest events the phase left queued get seen
      for (int t = 0; t < TAIL_READS; t++)
        drive_beat(OP_READ, 3'($urandom), 24'($urandom), 24'($urandom), 1'b0, NO_EVENT);
    end

    wait_drained();
    $display("Sent %0d beats (%0d reads) over %0d register writes and %0d phases;",
             beats_in, reads_in, reg_writes, PHASE_COUNT);
    $display("checked %0d result beats, %0d of them carrying key events.",
             results_out, events_out);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kmd_pkg.sv
rtl/kmd_front.sv
rtl/kmd_fifo.sv
rtl/kmd_back.sv
rtl/keypad_matrix_debounce_events.sv
rtl/kmd_checker.sv
tb/sv/tb_top.sv
